[src/ecpa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpa_pkg
// Shared types, codes and modular helpers for the elliptic-curve point unit.
// ----------------------------------------------------------------------------
package ecpa_pkg;

   localparam int FIELD_BITS  = 64;
   localparam int SCALAR_BITS = 64;
   localparam int CNT_BITS    = $clog2(FIELD_BITS);
   localparam int SCNT_BITS   = $clog2(SCALAR_BITS);
   localparam int MODE_BITS   = 3;
   localparam int CSR_IDX_BITS = 2;

   typedef logic [FIELD_BITS-1:0] field_type;

   // operation codes of an input beat
   localparam logic [MODE_BITS-1:0] MODE_ADD    = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_SUB    = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_SMUL   = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_NEGATE = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_CHECK  = 3'd4;

   // configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIELD_PRIME = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CURVE_A     = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CURVE_B     = 2'd2;

   localparam field_type PRIME_RESET = field_type'(3);
   localparam field_type FIELD_ONE   = field_type'(1);
   localparam field_type FIELD_TWO   = field_type'(2);
   localparam field_type FIELD_THREE = field_type'(3);

   typedef struct packed {
      logic [MODE_BITS-1:0]   mode;
      logic [63:0]            first_x;
      logic [63:0]            first_y;
      logic                   first_at_infinity;
      logic [63:0]            second_x;
      logic [63:0]            second_y;
      logic                   second_at_infinity;
      logic signed [63:0]     scalar;
   } req_type;

   typedef struct packed {
      logic [63:0] result_x;
      logic [63:0] result_y;
      logic        result_at_infinity;
      logic        on_curve;
   } rsp_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_rsp_type;

   // (u + v) mod p for u, v below p
   function automatic field_type mod_add(input field_type u, input field_type v,
                                         input field_type p);
      logic [FIELD_BITS:0] s;
      s = {1'b0, u} + {1'b0, v};
      if (s >= {1'b0, p}) begin
         s = s - {1'b0, p};
      end
      return s[FIELD_BITS-1:0];
   endfunction

   // (u - v) mod p for u, v below p
   function automatic field_type mod_sub(input field_type u, input field_type v,
                                         input field_type p);
      logic [FIELD_BITS:0] d;
      d = {1'b0, u} - {1'b0, v};
      if (d[FIELD_BITS]) begin
         return d[FIELD_BITS-1:0] + p;
      end
      return d[FIELD_BITS-1:0];
   endfunction

endpackage

[src/ecpa_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpa_alu
// Shared modular unit: add and subtract finish in the cycle after the start;
// multiply by bit-serial double-and-add: per multiplier bit, double, then add the multiplicand if the bit is set.
// ----------------------------------------------------------------------------
module ecpa_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  ecpa_pkg::alu_req_type alu_req,
   input  ecpa_pkg::field_type   op_u,
   input  ecpa_pkg::field_type   op_v,
   input  ecpa_pkg::field_type   modulus,
   output ecpa_pkg::alu_rsp_type alu_rsp,
   output ecpa_pkg::field_type   result
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic                               phase_ff, phase_in;
   logic [ecpa_pkg::CNT_BITS-1:0]      cnt_ff, cnt_in;
   ecpa_pkg::field_type                acc_ff, acc_in;
   ecpa_pkg::field_type                u_ff, u_in;
   ecpa_pkg::field_type                v_ff, v_in;

   // next-state logic
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      if (alu_req.start) begin
         u_in     = op_u;
         v_in     = op_v;
         cnt_in   = ecpa_pkg::CNT_BITS'(ecpa_pkg::FIELD_BITS - 1);
         phase_in = 1'b0;
         unique case (alu_req.op)
            ecpa_pkg::ALU_ADD: begin
               acc_in  = ecpa_pkg::mod_add(op_u, op_v, modulus);
               done_in = 1'b1;
            end
            ecpa_pkg::ALU_SUB: begin
               acc_in  = ecpa_pkg::mod_sub(op_u, op_v, modulus);
               done_in = 1'b1;
            end
            ecpa_pkg::ALU_MUL: begin
               acc_in  = '0;
               busy_in = 1'b1;
            end
            default: begin
               acc_in  = '0;
               done_in = 1'b1;
            end
         endcase
      end else if (busy_ff) begin
         // doubling step, then conditional add of the multiplicand
         if (!phase_ff) begin
            acc_in   = ecpa_pkg::mod_add(acc_ff, acc_ff, modulus);
            phase_in = 1'b1;
         end else begin
            if (v_ff[cnt_ff]) begin
               acc_in = ecpa_pkg::mod_add(acc_ff, u_ff, modulus);
            end
            phase_in = 1'b0;
            if (cnt_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               cnt_in = cnt_ff - ecpa_pkg::CNT_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      phase_ff <= phase_in;
      cnt_ff   <= cnt_in;
      acc_ff   <= acc_in;
      u_ff     <= u_in;
      v_ff     <= v_in;
   end

   assign alu_rsp.busy = busy_ff;
   assign alu_rsp.done = done_ff;
   assign result       = acc_ff;

endmodule

[src/ec_point_arithmetic_unit_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ec_point_arithmetic_unit_core
// Affine short-Weierstrass point add, subtract, signed scalar multiply,
// negate and on-curve check over a configurable prime field.
// ----------------------------------------------------------------------------
//  channel   dir   handshake               payload
//  req_      in    req_valid / req_ready   req_data  (ecpa_pkg::req_type)
//  rsp_      out   rsp_valid / rsp_ready   rsp_data  (ecpa_pkg::rsp_type)
//  csr_      in    csr_valid / csr_ready   csr_index, csr_data
//
//  every step runs on one shared modular unit; operand reduction takes six
//  multiplies; an inversion is a 64-bit exponentiation, up to 128 multiplies
//  one beat in flight; req_ready is low from accept until the result is loaded
//  reset is synchronous; a stalled rsp_ready holds the result register
// ----------------------------------------------------------------------------
module ec_point_arithmetic_unit_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  ecpa_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output ecpa_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ecpa_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [63:0]                           csr_data
);

   typedef enum logic [5:0] {
      S_IDLE, S_RED_A, S_RED_B, S_RED_QX, S_RED_QY, S_RED_TX, S_RED_TY,
      S_DISPATCH, S_NEG_T, S_NEG_Q, S_NEG_S,
      S_M_INIT, S_M_DBL, S_M_BIT, S_M_NXT,
      S_C_0, S_C_1, S_C_2, S_C_3, S_C_4, S_C_5,
      S_PA, S_D_0, S_D_1, S_D_2, S_D_3, S_A_0, S_A_1,
      S_IV_INIT, S_IV_SQ, S_IV_ML, S_IV_NX,
      S_L_0, S_L_1, S_L_2, S_L_3, S_L_4, S_L_5, S_L_6,
      S_FIN
   } state_type;

   state_type                          state_ff, ret_ff, op_next;
   logic                               issued_ff;
   ecpa_pkg::req_type                  req_ff;
   ecpa_pkg::rsp_type                  rsp_ff;
   logic                               rsp_valid_ff;
   ecpa_pkg::field_type                prime_ff, curve_a_ff, curve_b_ff;
   ecpa_pkg::field_type                wa_ff, wb_ff;
   ecpa_pkg::field_type                sx_ff, sy_ff, tx_ff, ty_ff, qx_ff, qy_ff;
   logic                               sinf_ff, tinf_ff, qinf_ff;
   ecpa_pkg::field_type                lam_ff, t0_ff, t1_ff, pr_ff;
   logic [ecpa_pkg::SCALAR_BITS-1:0]   kmag_ff;
   logic [ecpa_pkg::SCNT_BITS-1:0]     kidx_ff;
   logic [ecpa_pkg::CNT_BITS-1:0]      iidx_ff;
   logic                               chk_ff;

   ecpa_pkg::field_type                wp, inv_exp, three;
   logic                               is_op;
   logic                               rsp_load;
   ecpa_pkg::alu_op_type               alu_op;
   ecpa_pkg::alu_req_type              alu_req;
   ecpa_pkg::alu_rsp_type              alu_rsp;
   ecpa_pkg::field_type                op_u, op_v, alu_result;

   // working modulus and derived constants
   assign wp      = (prime_ff < ecpa_pkg::FIELD_THREE) ? ecpa_pkg::FIELD_THREE : prime_ff;
   assign inv_exp = wp - ecpa_pkg::FIELD_TWO;
   assign three   = (wp == ecpa_pkg::FIELD_THREE) ? '0 : ecpa_pkg::FIELD_THREE;

   // operand selection for states that use the shared unit
   always_comb begin
      is_op      = 1'b1;
      alu_op     = ecpa_pkg::ALU_MUL;
      op_u       = ecpa_pkg::FIELD_ONE;
      op_v       = '0;
      op_next    = S_IDLE;
      unique case (state_ff)
         S_RED_A:  begin op_v = curve_a_ff;      op_next = S_RED_B;    end
         S_RED_B:  begin op_v = curve_b_ff;      op_next = S_RED_QX;   end
         S_RED_QX: begin op_v = req_ff.first_x;  op_next = S_RED_QY;   end
         S_RED_QY: begin op_v = req_ff.first_y;  op_next = S_RED_TX;   end
         S_RED_TX: begin op_v = req_ff.second_x; op_next = S_RED_TY;   end
         S_RED_TY: begin op_v = req_ff.second_y; op_next = S_DISPATCH; end
         S_NEG_T: begin
            alu_op = ecpa_pkg::ALU_SUB; op_u = '0; op_v = ty_ff; op_next = S_PA;
         end
         S_NEG_Q: begin
            alu_op = ecpa_pkg::ALU_SUB; op_u = '0; op_v = qy_ff; op_next = S_M_INIT;
         end
         S_NEG_S: begin
            alu_op = ecpa_pkg::ALU_SUB; op_u = '0; op_v = sy_ff; op_next = S_FIN;
         end
         S_C_0: begin op_u = qy_ff; op_v = qy_ff; op_next = S_C_1; end
         S_C_1: begin op_u = qx_ff; op_v = qx_ff; op_next = S_C_2; end
         S_C_2: begin
            alu_op = ecpa_pkg::ALU_ADD; op_u = t1_ff; op_v = wa_ff; op_next = S_C_3;
         end
         S_C_3: begin op_u = qx_ff; op_v = t1_ff; op_next = S_C_4; end
         S_C_4: begin
            alu_op = ecpa_pkg::ALU_ADD; op_u = t1_ff; op_v = wb_ff; op_next = S_C_5;
         end
         S_D_0: begin op_u = sx_ff; op_v = sx_ff; op_next = S_D_1; end
         S_D_1: begin op_u = t0_ff; op_v = three; op_next = S_D_2; end
         S_D_2: begin
            alu_op = ecpa_pkg::ALU_ADD; op_u = t0_ff; op_v = wa_ff; op_next = S_D_3;
         end
         S_D_3: begin
            alu_op = ecpa_pkg::ALU_ADD; op_u = sy_ff; op_v = sy_ff; op_next = S_IV_INIT;
         end
         S_A_0: begin
            alu_op = ecpa_pkg::ALU_SUB; op_u = ty_ff; op_v = sy_ff; op_next = S_A_1;
         end
         S_A_1: begin
            alu_op = ecpa_pkg::ALU_SUB; op_u = tx_ff; op_v = sx_ff; op_next = S_IV_INIT;
         end
         S_IV_SQ: begin
            op_u = pr_ff; op_v = pr_ff;
            op_next = inv_exp[iidx_ff] ? S_IV_ML : S_IV_NX;
         end
         S_IV_ML: begin op_u = pr_ff;  op_v = t1_ff;  op_next = S_IV_NX; end
         S_L_0:   begin op_u = lam_ff; op_v = pr_ff;  op_next = S_L_1;   end
         S_L_1:   begin op_u = lam_ff; op_v = lam_ff; op_next = S_L_2;   end
         S_L_2: begin
            alu_op = ecpa_pkg::ALU_SUB; op_u = t0_ff; op_v = sx_ff; op_next = S_L_3;
         end
         S_L_3: begin
            alu_op = ecpa_pkg::ALU_SUB; op_u = t0_ff; op_v = tx_ff; op_next = S_L_4;
         end
         S_L_4: begin
            alu_op = ecpa_pkg::ALU_SUB; op_u = sx_ff; op_v = t0_ff; op_next = S_L_5;
         end
         S_L_5: begin op_u = lam_ff; op_v = t1_ff; op_next = S_L_6; end
         S_L_6: begin
            alu_op = ecpa_pkg::ALU_SUB; op_u = t1_ff; op_v = sy_ff; op_next = ret_ff;
         end
         default: is_op = 1'b0;
      endcase
   end

   assign alu_req = '{start: is_op && !issued_ff, op: alu_op};

   ecpa_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .op_u    (op_u),
      .op_v    (op_v),
      .modulus (wp),
      .alu_rsp (alu_rsp),
      .result  (alu_result)
   );

   // result register loads when empty or drained in the same cycle
   assign rsp_load  = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sequencer, working registers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_FIN;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prime_ff     <= ecpa_pkg::PRIME_RESET;
         curve_a_ff   <= '0;
         curve_b_ff   <= '0;
      end else begin
         // configuration writes
         if (csr_valid) begin
            case (csr_index)
               ecpa_pkg::CSR_FIELD_PRIME: prime_ff   <= csr_data;
               ecpa_pkg::CSR_CURVE_A:     curve_a_ff <= csr_data;
               ecpa_pkg::CSR_CURVE_B:     curve_b_ff <= csr_data;
               default: ;
            endcase
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (alu_req.start) begin
            issued_ff <= 1'b1;
         end

         if (is_op) begin
            // result write-back of the shared unit
            if (alu_rsp.done) begin
               issued_ff <= 1'b0;
               state_ff  <= op_next;
               unique case (state_ff)
                  S_RED_A:  wa_ff <= alu_result;
                  S_RED_B:  wb_ff <= alu_result;
                  S_RED_QX: qx_ff <= alu_result;
                  S_RED_QY: qy_ff <= alu_result;
                  S_RED_TX: tx_ff <= alu_result;
                  S_RED_TY: ty_ff <= alu_result;
                  S_NEG_T:  ty_ff <= alu_result;
                  S_NEG_Q:  qy_ff <= alu_result;
                  S_NEG_S:  sy_ff <= alu_result;
                  S_C_0, S_D_0, S_D_1, S_L_1, S_L_2, S_L_3: t0_ff <= alu_result;
                  S_C_1, S_C_2, S_C_3, S_C_4, S_D_3, S_A_1, S_L_4, S_L_5:
                     t1_ff <= alu_result;
                  S_D_2, S_A_0, S_L_0: lam_ff <= alu_result;
                  S_IV_SQ, S_IV_ML: pr_ff <= alu_result;
                  S_L_6: begin
                     sy_ff   <= alu_result;
                     sx_ff   <= t0_ff;
                     sinf_ff <= 1'b0;
                  end
                  default: ;
               endcase
            end
         end else begin
            unique case (state_ff)
               S_IDLE: begin
                  if (req_valid) begin
                     req_ff   <= req_data;
                     qinf_ff  <= req_data.first_at_infinity;
                     tinf_ff  <= req_data.second_at_infinity;
                     chk_ff   <= 1'b0;
                     ret_ff   <= S_FIN;
                     state_ff <= S_RED_A;
                  end
               end
               S_DISPATCH: begin
                  // unused modes give infinity
                  sx_ff   <= qx_ff;
                  sy_ff   <= qy_ff;
                  sinf_ff <= qinf_ff || (req_ff.mode > ecpa_pkg::MODE_CHECK);
                  ret_ff  <= S_FIN;
                  priority case (req_ff.mode)
                     ecpa_pkg::MODE_ADD:    state_ff <= S_PA;
                     ecpa_pkg::MODE_SUB:    state_ff <= S_NEG_T;
                     ecpa_pkg::MODE_SMUL:
                        state_ff <= req_ff.scalar[ecpa_pkg::SCALAR_BITS-1] ? S_NEG_Q
                                                                           : S_M_INIT;
                     ecpa_pkg::MODE_NEGATE: state_ff <= S_NEG_S;
                     ecpa_pkg::MODE_CHECK: begin
                        if (qinf_ff) begin
                           chk_ff   <= 1'b1;
                           state_ff <= S_FIN;
                        end else begin
                           state_ff <= S_C_0;
                        end
                     end
                     default: begin
                        state_ff <= S_FIN;
                     end
                  endcase
               end
               // scalar multiply, most significant bit first
               S_M_INIT: begin
                  sinf_ff  <= 1'b1;
                  kmag_ff  <= req_ff.scalar[ecpa_pkg::SCALAR_BITS-1]
                              ? (ecpa_pkg::SCALAR_BITS'(0) - req_ff.scalar)
                              : req_ff.scalar;
                  kidx_ff  <= ecpa_pkg::SCNT_BITS'(ecpa_pkg::SCALAR_BITS - 1);
                  state_ff <= S_M_DBL;
               end
               S_M_DBL: begin
                  tx_ff    <= sx_ff;
                  ty_ff    <= sy_ff;
                  tinf_ff  <= sinf_ff;
                  ret_ff   <= S_M_BIT;
                  state_ff <= S_PA;
               end
               S_M_BIT: begin
                  if (kmag_ff[kidx_ff]) begin
                     tx_ff    <= qx_ff;
                     ty_ff    <= qy_ff;
                     tinf_ff  <= qinf_ff;
                     ret_ff   <= S_M_NXT;
                     state_ff <= S_PA;
                  end else begin
                     state_ff <= S_M_NXT;
                  end
               end
               S_M_NXT: begin
                  if (kidx_ff == '0) begin
                     state_ff <= S_FIN;
                  end else begin
                     kidx_ff  <= kidx_ff - ecpa_pkg::SCNT_BITS'(1);
                     state_ff <= S_M_DBL;
                  end
               end
               S_C_5: begin
                  chk_ff   <= (t0_ff == t1_ff);
                  state_ff <= S_FIN;
               end
               // point add entry: infinity, inverse, doubling and general add cases
               S_PA: begin
                  priority if (sinf_ff) begin
                     sx_ff    <= tx_ff;
                     sy_ff    <= ty_ff;
                     sinf_ff  <= tinf_ff;
                     state_ff <= ret_ff;
                  end else if (tinf_ff) begin
                     state_ff <= ret_ff;
                  end else if (sx_ff == tx_ff) begin
                     if ((sy_ff != ty_ff) || (sy_ff == '0)) begin
                        sinf_ff  <= 1'b1;
                        state_ff <= ret_ff;
                     end else begin
                        state_ff <= S_D_0;
                     end
                  end else begin
                     state_ff <= S_A_0;
                  end
               end
               // inverse by exponent p - 2
               S_IV_INIT: begin
                  pr_ff    <= ecpa_pkg::FIELD_ONE;
                  iidx_ff  <= ecpa_pkg::CNT_BITS'(ecpa_pkg::FIELD_BITS - 1);
                  state_ff <= S_IV_SQ;
               end
               S_IV_NX: begin
                  if (iidx_ff == '0) begin
                     state_ff <= S_L_0;
                  end else begin
                     iidx_ff  <= iidx_ff - ecpa_pkg::CNT_BITS'(1);
                     state_ff <= S_IV_SQ;
                  end
               end
               S_FIN: begin
                  if (rsp_load) begin
                     rsp_ff.result_x             <= sinf_ff ? '0 : sx_ff;
                     rsp_ff.result_y             <= sinf_ff ? '0 : sy_ff;
                     rsp_ff.result_at_infinity   <= sinf_ff;
                     rsp_ff.on_curve             <= chk_ff;
                     state_ff                    <= S_IDLE;
                  end
               end
               default: state_ff <= S_IDLE;
            endcase
         end
      end
   end

   // the shared unit is never restarted while a multiply runs
   assert property (@(posedge clock) disable iff (reset)
      alu_req.start |-> !alu_rsp.busy)
      else $error("shared unit started while busy");

   // every unit result is a reduced residue
   assert property (@(posedge clock) disable iff (reset)
      alu_rsp.done |-> (alu_result < wp))
      else $error("unit result not reduced");

   // an infinite result carries zero coordinates
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.result_at_infinity
         |-> (rsp_ff.result_x == '0) && (rsp_ff.result_y == '0))
      else $error("infinite result with nonzero coordinates");

   // the on-curve flag is only raised by the check operation
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) && chk_ff |-> (req_ff.mode == ecpa_pkg::MODE_CHECK))
      else $error("on-curve flag outside check operation");

endmodule
